// File: rtl/dbre_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types for the diffuse BRDF evaluator pipeline.
// No dependencies; used by diffuse_brdf_evaluator_unit.
package dbre_pkg;

	// Default parameter values
	localparam int DIR_FRAC_BITS_DEF = 15;
	localparam int OUT_FRAC_BITS_DEF = 16;

	// Fixed point constants (internal quantities are unsigned Q.30)
	localparam logic [30:0] ONE_Q30    = 31'h4000_0000;
	localparam logic [31:0] HALF_Q30   = 32'h2000_0000;
	localparam logic [28:0] INV_PI_Q30 = 29'd341782638;
	localparam logic [16:0] WORK_ONE   = 17'd32768;

	// Saturation limits of the result fields
	localparam logic [17:0] REFL_MAX = 18'h3FFFF;
	localparam logic [15:0] PDF_MAX  = 16'hFFFF;

	// Restoring divider: quotient bits produced and dividend alignment
	localparam int DIV_STEPS   = 46;
	localparam int DIV_D_SHIFT = 30;

	// Per-query data that rides along the pipeline up to the albedo products
	typedef struct packed {
		logic [15:0] rough;
		logic [15:0] alb_r;
		logic [15:0] alb_g;
		logic [15:0] alb_b;
		logic [15:0] woz;
		logic [15:0] wiz;
		logic        ok;
	} side_t;

	// One stage of the half-vector divider
	typedef struct packed {
		logic [33:0] rem;
		logic [45:0] quo;
		logic [32:0] d;
		logic [33:0] n2;
	} div_t;

endpackage

// File: rtl/diffuse_brdf_evaluator_unit.sv
`timescale 1ns / 1ps
// Diffuse BRDF evaluator: half-vector term, fifth-power Fresnel weights, lobe and pdf.
// Depends on dbre_pkg for constants and stage types.
//
// Channel  Dir  Fields (lowest bit first)
// s_*      in   tdata: in_dir_x/y/z, out_dir_x/y/z, rough_val, albedo_r/g/b; tuser: en, active
// m_*      out  tdata: refl_r/g/b, hemi_pdf (2 pad bits); tuser: result_valid
//
// One query is accepted every cycle while the output is not stalled.
// The depth is set by the 46-stage restoring divider for the half-vector quotient.
// A stall on the output freezes every stage together; nothing is dropped or repeated.
// arst_n clears all stage valid bits; payload registers are not reset.
module diffuse_brdf_evaluator_unit #(
	parameter int DIR_FRAC_BITS = dbre_pkg::DIR_FRAC_BITS_DEF,
	parameter int OUT_FRAC_BITS = dbre_pkg::OUT_FRAC_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// in_dir_x, in_dir_y, in_dir_z, out_dir_x, out_dir_y, out_dir_z,
	// rough_val, albedo_r, albedo_g, albedo_b
	input  logic [159:0] s_tdata,
	// diffuse_enabled, lane_active
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// refl_r, refl_g, refl_b, hemi_pdf, two zero pad bits
	output logic [71:0]  m_tdata,
	// result_valid
	output logic [0:0]   m_tuser
);

	localparam int SHR     = (DIR_FRAC_BITS >= 15) ? ((DIR_FRAC_BITS - 15) % 16) : 0;
	localparam int SHL     = (DIR_FRAC_BITS < 15) ? ((15 - DIR_FRAC_BITS) % 16) : 0;
	localparam int ALIGN_W = 17 + SHL;
	localparam int REFL_SH = 46 - OUT_FRAC_BITS;
	localparam int PDF_SH  = 30 - OUT_FRAC_BITS;
	localparam int NDIV    = dbre_pkg::DIV_STEPS;

	// Align a raw component to 15 fraction bits, magnitude saturated to 1.0
	function automatic logic signed [16:0] align_comp(input logic [15:0] raw);
		logic                neg;
		logic [16:0]         mag0;
		logic [ALIGN_W-1:0]  mag;
		logic [16:0]         mag_sat;
		neg  = raw[15];
		mag0 = neg ? (17'd0 - {raw[15], raw}) : {raw[15], raw};
		mag  = (ALIGN_W'(mag0) << SHL) >> SHR;
		mag_sat = (mag > ALIGN_W'(dbre_pkg::WORK_ONE)) ? dbre_pkg::WORK_ONE : mag[16:0];
		return neg ? signed'(17'd0 - mag_sat) : signed'(mag_sat);
	endfunction

	logic adv;

	// Advance every stage unless the output holds an untaken transaction
	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;

	// ---------------- Stage 1: unpack and align ----------------
	logic signed [16:0] wi_s1 [3];
	logic signed [16:0] wo_s1 [3];
	dbre_pkg::side_t    side_s1;
	logic               v_s1;
	dbre_pkg::side_t    side_in;
	logic signed [16:0] wi_in [3];
	logic signed [16:0] wo_in [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			wi_in[i] = align_comp(s_tdata[16*i +: 16]);
			wo_in[i] = align_comp(s_tdata[48 + 16*i +: 16]);
		end
		side_in.rough = s_tdata[111:96];
		side_in.alb_r = s_tdata[127:112];
		side_in.alb_g = s_tdata[143:128];
		side_in.alb_b = s_tdata[159:144];
		side_in.woz   = wo_in[2][15:0];
		side_in.wiz   = wi_in[2][15:0];
		side_in.ok    = !s_tdata[47] && (s_tdata[47:32] != 16'd0) &&
			!s_tdata[95] && (s_tdata[95:80] != 16'd0) && s_tuser[0] && s_tuser[1];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			wi_s1   <= wi_in;
			wo_s1   <= wo_in;
			side_s1 <= side_in;
		end
	end

	// ---------------- Stage 2: sum vector and products ----------------
	logic signed [17:0] sv [3];
	logic signed [34:0] pw_s2 [3];
	logic        [32:0] ps_s2 [3];
	dbre_pkg::side_t    side_s2;
	logic               v_s2;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sv[i] = 18'(wi_s1[i]) + 18'(wo_s1[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				pw_s2[i] <= 35'(wo_s1[i]) * 35'(sv[i]);
				ps_s2[i] <= 33'(36'(sv[i]) * 36'(sv[i]));
			end
			side_s2 <= side_s1;
		end
	end

	// ---------------- Stage 3: dot product and squared norm ----------------
	logic signed [34:0] dots;
	logic        [32:0] d_s3;
	logic        [33:0] n2_s3;
	dbre_pkg::side_t    side_s3;
	logic               v_s3;

	assign dots = pw_s2[0] + pw_s2[1] + pw_s2[2];

	always_ff @(posedge clk) begin
		if (adv) begin
			d_s3    <= dots[34] ? 33'(35'd0 - dots) : dots[32:0];
			n2_s3   <= 34'(ps_s2[0]) + 34'(ps_s2[1]) + 34'(ps_s2[2]);
			side_s3 <= side_s2;
		end
	end

	// ---------------- Stage 4: restoring divider, one quotient bit per stage ----------------
	dbre_pkg::div_t  div_s4  [NDIV];
	dbre_pkg::side_t side_s4 [NDIV];
	logic            v_s4    [NDIV];

	genvar k;
	for (k = 0; k < NDIV; k++) begin : g_div
		localparam int BIT = NDIV - 1 - k;
		dbre_pkg::div_t  prev;
		dbre_pkg::side_t prev_side;
		dbre_pkg::div_t  nxt;
		logic            prev_v;
		logic            bin;
		logic [34:0]     trial;
		logic            ge;

		if (k == 0) begin : g_first
			assign prev = '{rem: 34'(n2_s3 == 34'd0 ? 33'd0 : (d_s3 >> 16)),
				quo: '0, d: d_s3, n2: n2_s3};
			assign prev_side = side_s3;
			assign prev_v    = v_s3;
		end else begin : g_next
			assign prev      = div_s4[k-1];
			assign prev_side = side_s4[k-1];
			assign prev_v    = v_s4[k-1];
		end

		if (BIT >= dbre_pkg::DIV_D_SHIFT) begin : g_dbit
			assign bin = prev.d[BIT - dbre_pkg::DIV_D_SHIFT];
		end else begin : g_zbit
			assign bin = 1'b0;
		end

		// Shift in the next dividend bit, subtract when it fits
		always_comb begin
			trial    = {prev.rem, bin};
			ge       = trial >= {1'b0, prev.n2};
			nxt      = prev;
			nxt.rem  = ge ? 34'(trial - {1'b0, prev.n2}) : trial[33:0];
			nxt.quo[BIT] = ge;
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				div_s4[k]  <= nxt;
				side_s4[k] <= prev_side;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s4[k] <= 1'b0;
			end else if (adv) begin
				v_s4[k] <= prev_v;
			end
		end
	end

	// ---------------- Stage 5: quotient partial products, Schlick squares ----------------
	dbre_pkg::div_t  dv_last;
	logic [55:0]     plo_s5, phi_s5;
	logic [30:0]     m2l_s5, m2v_s5;
	dbre_pkg::side_t side_s5;
	logic            v_s5;
	logic [15:0]     kl, kv;

	assign dv_last = div_s4[NDIV-1];
	assign kl = 16'(dbre_pkg::WORK_ONE - {1'b0, side_s4[NDIV-1].woz});
	assign kv = 16'(dbre_pkg::WORK_ONE - {1'b0, side_s4[NDIV-1].wiz});

	always_ff @(posedge clk) begin
		if (adv) begin
			plo_s5  <= 56'(dv_last.quo[22:0]) * 56'(dv_last.d);
			phi_s5  <= 56'(dv_last.quo[45:23]) * 56'(dv_last.d);
			m2l_s5  <= 31'(32'(kl) * 32'(kl));
			m2v_s5  <= 31'(32'(kv) * 32'(kv));
			side_s5 <= side_s4[NDIV-1];
		end
	end

	// ---------------- Stage 6: LdotH^2 with saturation, fourth powers ----------------
	logic [78:0]     prod;
	logic [48:0]     xt;
	logic [30:0]     x_s6, m4l_s6, m4v_s6;
	dbre_pkg::side_t side_s6;
	logic            v_s6;

	assign prod = {phi_s5, 23'd0} + 79'(plo_s5);
	assign xt   = prod[78:30];

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s6    <= (xt > 49'(dbre_pkg::ONE_Q30)) ? dbre_pkg::ONE_Q30 : xt[30:0];
			m4l_s6  <= 31'((62'(m2l_s5) * 62'(m2l_s5)) >> 30);
			m4v_s6  <= 31'((62'(m2v_s5) * 62'(m2v_s5)) >> 30);
			side_s6 <= side_s5;
		end
	end

	// ---------------- Stage 7: fifth powers, roughness term ----------------
	logic [30:0]     ml, mv;
	logic [30:0]     fl_s7, fv_s7;
	logic [29:0]     mx_s7;
	dbre_pkg::side_t side_s7;
	logic            v_s7;

	assign ml = {16'(dbre_pkg::WORK_ONE - {1'b0, side_s6.woz}), 15'd0};
	assign mv = {16'(dbre_pkg::WORK_ONE - {1'b0, side_s6.wiz}), 15'd0};

	always_ff @(posedge clk) begin
		if (adv) begin
			fl_s7   <= 31'((62'(m4l_s6) * 62'(ml)) >> 30);
			fv_s7   <= 31'((62'(m4v_s6) * 62'(mv)) >> 30);
			mx_s7   <= 30'((61'(x_s6) * 61'({side_s6.rough, 14'd0})) >> 30);
			side_s7 <= side_s6;
		end
	end

	// ---------------- Stage 8: retro-reflection term Fd90 ----------------
	logic [31:0]     fd90_s8;
	logic [30:0]     fl_s8, fv_s8;
	dbre_pkg::side_t side_s8;
	logic            v_s8;

	always_ff @(posedge clk) begin
		if (adv) begin
			fd90_s8 <= dbre_pkg::HALF_Q30 + {1'b0, mx_s7, 1'b0};
			fl_s8   <= fl_s7;
			fv_s8   <= fv_s7;
			side_s8 <= side_s7;
		end
	end

	// ---------------- Stage 9: Fd90 times Fresnel weights ----------------
	logic [31:0]     tl_s9, tv_s9;
	logic [30:0]     fl_s9, fv_s9;
	dbre_pkg::side_t side_s9;
	logic            v_s9;

	always_ff @(posedge clk) begin
		if (adv) begin
			tl_s9   <= 32'((63'(fd90_s8) * 63'(fl_s8)) >> 30);
			tv_s9   <= 32'((63'(fd90_s8) * 63'(fv_s8)) >> 30);
			fl_s9   <= fl_s8;
			fv_s9   <= fv_s8;
			side_s9 <= side_s8;
		end
	end

	// ---------------- Stage 10: per-direction factors ----------------
	logic [32:0]     a_s10, b_s10;
	dbre_pkg::side_t side_s10;
	logic            v_s10;

	always_ff @(posedge clk) begin
		if (adv) begin
			a_s10    <= 33'(dbre_pkg::ONE_Q30) - 33'(fl_s9) + 33'(tl_s9);
			b_s10    <= 33'(dbre_pkg::ONE_Q30) - 33'(fv_s9) + 33'(tv_s9);
			side_s10 <= side_s9;
		end
	end

	// ---------------- Stage 11: Fd product ----------------
	logic [34:0]     fd_s11;
	dbre_pkg::side_t side_s11;
	logic            v_s11;

	always_ff @(posedge clk) begin
		if (adv) begin
			fd_s11   <= 35'((66'(a_s10) * 66'(b_s10)) >> 30);
			side_s11 <= side_s10;
		end
	end

	// ---------------- Stage 12: cosine weighting, pdf ----------------
	logic [30:0]     cl;
	logic [34:0]     g_s12;
	logic [28:0]     pdf_s12;
	dbre_pkg::side_t side_s12;
	logic            v_s12;

	assign cl = {side_s11.woz, 15'd0};

	always_ff @(posedge clk) begin
		if (adv) begin
			g_s12    <= 35'((66'(fd_s11) * 66'(cl)) >> 30);
			pdf_s12  <= 29'((60'(cl) * 60'(dbre_pkg::INV_PI_Q30)) >> 30);
			side_s12 <= side_s11;
		end
	end

	// ---------------- Stage 13: divide by pi ----------------
	logic [33:0]     lobe_s13;
	logic [28:0]     pdf_s13;
	dbre_pkg::side_t side_s13;
	logic            v_s13;

	always_ff @(posedge clk) begin
		if (adv) begin
			lobe_s13 <= 34'((64'(g_s12) * 64'(dbre_pkg::INV_PI_Q30)) >> 30);
			pdf_s13  <= pdf_s12;
			side_s13 <= side_s12;
		end
	end

	// ---------------- Stage 14: albedo products ----------------
	logic [49:0]     pr_s14, pg_s14, pb_s14;
	logic [28:0]     pdf_s14;
	logic            ok_s14;
	logic            v_s14;

	always_ff @(posedge clk) begin
		if (adv) begin
			pr_s14  <= 50'(side_s13.alb_r) * 50'(lobe_s13);
			pg_s14  <= 50'(side_s13.alb_g) * 50'(lobe_s13);
			pb_s14  <= 50'(side_s13.alb_b) * 50'(lobe_s13);
			pdf_s14 <= pdf_s13;
			ok_s14  <= side_s13.ok;
		end
	end

	// ---------------- Stage 15: scale, saturate and output register ----------------
	logic [49:0] rr, rg, rb;
	logic [28:0] rp;
	logic [17:0] refl_r, refl_g, refl_b;
	logic [15:0] hemi_pdf;
	logic [71:0] tdata_s15;
	logic        ok_s15;
	logic        v_s15;

	assign rr = pr_s14 >> REFL_SH;
	assign rg = pg_s14 >> REFL_SH;
	assign rb = pb_s14 >> REFL_SH;
	assign rp = pdf_s14 >> PDF_SH;

	always_comb begin
		refl_r   = (rr > 50'(dbre_pkg::REFL_MAX)) ? dbre_pkg::REFL_MAX : rr[17:0];
		refl_g   = (rg > 50'(dbre_pkg::REFL_MAX)) ? dbre_pkg::REFL_MAX : rg[17:0];
		refl_b   = (rb > 50'(dbre_pkg::REFL_MAX)) ? dbre_pkg::REFL_MAX : rb[17:0];
		hemi_pdf = (rp > 29'(dbre_pkg::PDF_MAX)) ? dbre_pkg::PDF_MAX : rp[15:0];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tdata_s15 <= ok_s14 ? {2'b00, hemi_pdf, refl_b, refl_g, refl_r} : 72'd0;
			ok_s15    <= ok_s14;
		end
	end

	assign m_tvalid   = v_s15;
	assign m_tdata    = tdata_s15;
	assign m_tuser[0] = ok_s15;

	// Valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
			v_s12 <= 1'b0;
			v_s13 <= 1'b0;
			v_s14 <= 1'b0;
			v_s15 <= 1'b0;
		end else if (adv) begin
			v_s1  <= s_tvalid;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s5  <= v_s4[NDIV-1];
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
			v_s12 <= v_s11;
			v_s13 <= v_s12;
			v_s14 <= v_s13;
			v_s15 <= v_s14;
		end
	end

	// ---------------- Assertions ----------------
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[0]) |-> (m_tdata == 72'd0))
		else $error("invalid query produced nonzero data");

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |-> !s_tready)
		else $error("input taken while output stalled");

	a_div_remainder: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4[NDIV-1] && div_s4[NDIV-1].n2 != 34'd0) |->
		(div_s4[NDIV-1].rem < div_s4[NDIV-1].n2))
		else $error("divider remainder out of range");

endmodule
